FILE: hw/rtl/container_section_walker_defines.svh
// Assertion helpers for the checker of the section walker.
`ifndef CONTAINER_SECTION_WALKER_DEFINES_SVH
`define CONTAINER_SECTION_WALKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("section walker check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CSW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("section walker check failed");

`endif

FILE: hw/rtl/csw_pkg.sv
package csw_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int NEXT_W      = OFFSET_BITS + 1;
    localparam int POS_W       = 32;
    localparam int WIDE_W      = 34;

    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [WIDE_W-1:0] OFF_LIMIT = {{(WIDE_W-1){1'b0}}, 1'b1} << OFFSET_BITS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_INDEX = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_MAGIC = CFG_IDX_W'(1);

    localparam logic [15:0]      MARK_BOM_A    = 16'hFFFE;
    localparam logic [15:0]      MARK_BOM_B    = 16'hFEFF;
    localparam logic [POS_W-1:0] POS_HEAD_DONE = POS_W'(8);
    localparam logic [POS_W-1:0] POS_HDR_DONE  = POS_W'(16);
    localparam logic [15:0]      HLEN_MIN      = 16'h0010;
    localparam int               SEC_HDR_BYTES = 8;

    typedef enum logic [1:0] {
        KIND_BODY,
        KIND_HEAD,
        KIND_HDR,
        KIND_SKIP
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             last;
        logic [7:0]       data_byte;
        logic [POS_W-1:0] pos;
    } t_item;

endpackage

FILE: hw/rtl/csw_ifs.sv
interface csw_in_if
    import csw_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface csw_res_if
    import csw_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        file_ok;
    logic        old_format;
    logic [15:0] section_total;
    logic        index_hit;
    logic [31:0] index_offset;
    logic        magic_hit;
    logic [31:0] magic_offset;
    logic [31:0] total_bytes;

    modport source (output valid, output file_ok, output old_format, output section_total,
                    output index_hit, output index_offset, output magic_hit,
                    output magic_offset, output total_bytes, input ready);
    modport sink   (input valid, input file_ok, input old_format, input section_total,
                    input index_hit, input index_offset, input magic_hit,
                    input magic_offset, input total_bytes, output ready);
endinterface

interface csw_cfg_if
    import csw_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/container_section_walker.sv
// Channel   Dir  Item
// i_in      in   data_byte[7:0], last_byte
// o_res     out  file_ok, old_format, section_total, index/magic hit+offset, total_bytes
// i_cfg     in   index[7:0], data[31:0]; 0 target_index, 1 target_magic
//
// One byte per cycle unless the queue is full; the front tags bytes with their position
// into a 4-entry queue. The back walks one section header per cycle; a header ending on
// the newest byte goes alongside the next byte unless it is zero-length with more to
// count, any other holds it. A result registers once its last byte has left the queue,
// the headers left are walked and the output is free. Synchronous active-low reset; no
// clearing pass. A stalled result only blocks the back once the next file's last byte has been walked.
module container_section_walker
    import csw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    csw_in_if.sink     i_in,
    csw_res_if.source  o_res,
    csw_cfg_if.sink    i_cfg
);

    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    csw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    csw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    csw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .i_cfg       (i_cfg),
        .o_res       (o_res)
    );

endmodule

FILE: hw/rtl/csw_front.sv
module csw_front
    import csw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    csw_in_if.sink   i_in,
    output logic     o_push_valid,
    output t_item    o_push_item,
    input  logic     i_push_ready
);

    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] n_count;
    logic [POS_W-1:0] pos;
    t_kind            kind;
    logic             accept;

    assign i_in.ready   = i_push_ready;
    assign o_push_valid = i_in.valid;
    assign accept       = i_in.valid && i_push_ready;

    always_comb begin
        if (r_count == POS_MAX) begin
            pos  = r_count;
            kind = KIND_SKIP;
        end else begin
            pos = r_count + POS_W'(1);
            if (pos == POS_HEAD_DONE) begin
                kind = KIND_HEAD;
            end else if (pos == POS_HDR_DONE) begin
                kind = KIND_HDR;
            end else begin
                kind = KIND_BODY;
            end
        end
        n_count = r_count;
        if (accept) begin
            n_count = i_in.last_byte ? '0 : pos;
        end
    end

    assign o_push_item = '{kind: kind, last: i_in.last_byte, data_byte: i_in.data_byte,
                           pos: pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

FILE: hw/rtl/csw_queue.sv
module csw_queue
    import csw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_item i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_item o_pop_item,
    input  logic  i_pop_ready
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rp];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: hw/rtl/csw_back.sv
module csw_back
    import csw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pop_valid,
    input  t_item      i_pop_item,
    output logic       o_pop_ready,
    csw_cfg_if.sink    i_cfg,
    csw_res_if.source  o_res
);

    logic [15:0]            r_target_index;
    logic [31:0]            r_target_magic;

    logic [POS_W-1:0]       r_pos,       n_pos;
    logic [63:0]            r_window,    n_window;
    logic [63:0]            r_head,      n_head;
    logic [15:0]            r_marker,    n_marker;
    logic [31:0]            r_decl,      n_decl;
    logic [15:0]            r_hlen,      n_hlen;
    logic [15:0]            r_count,     n_count;
    logic                   r_hdr_rdy,   n_hdr_rdy;
    logic [NEXT_W-1:0]      r_next,      n_next;
    logic [15:0]            r_seen,      n_seen;
    logic                   r_idx_found, n_idx_found;
    logic [OFFSET_BITS-1:0] r_idx_off,   n_idx_off;
    logic                   r_mag_found, n_mag_found;
    logic [OFFSET_BITS-1:0] r_mag_off,   n_mag_off;
    logic                   r_pend_last, n_pend_last;

    logic                   r_out_valid;
    logic                   r_out_ok;
    logic                   r_out_old;
    logic [15:0]            r_out_total;
    logic                   r_out_ihit;
    logic [31:0]            r_out_ioff;
    logic                   r_out_mhit;
    logic [31:0]            r_out_moff;
    logic [31:0]            r_out_bytes;

    logic              old_fmt;
    logic              walk_go;
    logic [WIDE_W-1:0] next_w;
    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] gap;
    logic              gap_lt8;
    logic [2:0]        gap_lo;
    logic [7:0]        hb [SEC_HDR_BYTES];
    logic [31:0]       sec_magic;
    logic [31:0]       sec_len;
    logic [WIDE_W-1:0] len_eff;
    logic [WIDE_W-1:0] sum;
    logic [NEXT_W-1:0] next_sat;
    logic              pop_ok_walk;
    logic              out_free;
    logic              emit;
    logic              pop;
    logic [WIDE_W-1:0] size_w;
    logic [WIDE_W-1:0] decl_w;
    logic              mark_ok;
    logic              len_ok;
    logic              file_ok;
    logic [63:0]       shifted;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_index <= '0;
            r_target_magic <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TARGET_INDEX: r_target_index <= i_cfg.data[15:0];
                REG_TARGET_MAGIC: r_target_magic <= i_cfg.data[31:0];
                default: ;
            endcase
        end
    end

    // section header walk on the registered state
    assign old_fmt = (r_marker == 16'h0000);
    assign next_w  = WIDE_W'(r_next);
    assign pos_w   = WIDE_W'(r_pos);
    assign walk_go = r_hdr_rdy && (r_seen < r_count) && (next_w < OFF_LIMIT)
                     && (next_w + WIDE_W'(SEC_HDR_BYTES) <= pos_w);
    assign gap     = pos_w - next_w - WIDE_W'(SEC_HDR_BYTES);
    assign gap_lt8 = (gap < WIDE_W'(8));
    assign gap_lo  = gap[2:0];

    always_comb begin
        logic [2:0] kk;
        logic [2:0] wi;
        logic [2:0] hi;
        for (int k = 0; k < SEC_HDR_BYTES; k++) begin
            kk = 3'(k);
            wi = kk - gap_lo;
            hi = r_next[2:0] + kk;
            if (gap_lt8 && (kk >= gap_lo)) begin
                hb[k] = r_window[{wi, 3'b000} +: 8];
            end else if ((r_next < NEXT_W'(8))
                         && ({1'b0, r_next[2:0]} + {1'b0, kk} < 4'd8)) begin
                hb[k] = r_head[{hi, 3'b000} +: 8];
            end else begin
                hb[k] = 8'h00;
            end
        end
    end

    assign sec_magic = {hb[3], hb[2], hb[1], hb[0]};
    assign sec_len   = {hb[7], hb[6], hb[5], hb[4]};
    assign len_eff   = WIDE_W'(sec_len) + (old_fmt ? WIDE_W'(SEC_HDR_BYTES) : '0);
    assign sum       = next_w + len_eff;
    assign next_sat  = (sum > OFF_LIMIT) ? OFF_LIMIT[NEXT_W-1:0] : sum[NEXT_W-1:0];

    // a new byte may enter only if no pending header still needs the oldest window byte
    assign pop_ok_walk = !walk_go
                         || ((next_w + WIDE_W'(SEC_HDR_BYTES) == pos_w)
                             && ((len_eff != '0) || (r_seen + 16'd1 == r_count)));

    assign out_free    = !r_out_valid || o_res.ready;
    assign emit        = r_pend_last && !walk_go && out_free;
    assign o_pop_ready = r_pend_last ? emit : pop_ok_walk;
    assign pop         = i_pop_valid && o_pop_ready;

    // end of file checks
    assign size_w  = pos_w;
    assign decl_w  = WIDE_W'(r_decl);
    assign mark_ok = (r_marker == MARK_BOM_A) || (r_marker == MARK_BOM_B) || old_fmt;
    assign len_ok  = (decl_w == size_w)
                     || (old_fmt && (decl_w + WIDE_W'(SEC_HDR_BYTES) == size_w))
                     || (((decl_w + WIDE_W'(3)) & ~WIDE_W'(3)) == size_w);
    assign file_ok = r_hdr_rdy && mark_ok && len_ok && (r_hlen >= HLEN_MIN)
                     && (r_seen == r_count);

    always_comb begin
        n_pos       = r_pos;
        n_window    = r_window;
        n_head      = r_head;
        n_marker    = r_marker;
        n_decl      = r_decl;
        n_hlen      = r_hlen;
        n_count     = r_count;
        n_hdr_rdy   = r_hdr_rdy;
        n_next      = r_next;
        n_seen      = r_seen;
        n_idx_found = r_idx_found;
        n_idx_off   = r_idx_off;
        n_mag_found = r_mag_found;
        n_mag_off   = r_mag_off;
        n_pend_last = r_pend_last;
        shifted     = '0;

        if (walk_go) begin
            if ((r_seen == r_target_index) && !r_idx_found) begin
                n_idx_found = 1'b1;
                n_idx_off   = r_next[OFFSET_BITS-1:0];
            end
            if (!r_mag_found && (sec_magic == r_target_magic)) begin
                n_mag_found = 1'b1;
                n_mag_off   = r_next[OFFSET_BITS-1:0];
            end
            n_seen = r_seen + 16'd1;
            n_next = next_sat;
        end

        if (emit) begin
            n_pos       = '0;
            n_window    = '0;
            n_head      = '0;
            n_marker    = '0;
            n_decl      = '0;
            n_hlen      = '0;
            n_count     = '0;
            n_hdr_rdy   = 1'b0;
            n_next      = '0;
            n_seen      = '0;
            n_idx_found = 1'b0;
            n_idx_off   = '0;
            n_mag_found = 1'b0;
            n_mag_off   = '0;
            n_pend_last = 1'b0;
        end

        if (pop) begin
            shifted = {i_pop_item.data_byte, n_window[63:8]};
            if (i_pop_item.kind != KIND_SKIP) begin
                n_window = shifted;
                n_pos    = i_pop_item.pos;
            end
            case (i_pop_item.kind)
                KIND_HEAD: n_head = shifted;
                KIND_HDR: begin
                    n_marker  = n_head[47:32];
                    n_decl    = shifted[31:0];
                    n_hlen    = shifted[47:32];
                    n_count   = shifted[63:48];
                    n_next    = NEXT_W'(shifted[47:32]);
                    n_hdr_rdy = 1'b1;
                end
                default: ;
            endcase
            n_pend_last = i_pop_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_window    <= '0;
            r_head      <= '0;
            r_marker    <= '0;
            r_decl      <= '0;
            r_hlen      <= '0;
            r_count     <= '0;
            r_hdr_rdy   <= 1'b0;
            r_next      <= '0;
            r_seen      <= '0;
            r_idx_found <= 1'b0;
            r_idx_off   <= '0;
            r_mag_found <= 1'b0;
            r_mag_off   <= '0;
            r_pend_last <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_window    <= n_window;
            r_head      <= n_head;
            r_marker    <= n_marker;
            r_decl      <= n_decl;
            r_hlen      <= n_hlen;
            r_count     <= n_count;
            r_hdr_rdy   <= n_hdr_rdy;
            r_next      <= n_next;
            r_seen      <= n_seen;
            r_idx_found <= n_idx_found;
            r_idx_off   <= n_idx_off;
            r_mag_found <= n_mag_found;
            r_mag_off   <= n_mag_off;
            r_pend_last <= n_pend_last;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_ok    <= file_ok;
            r_out_old   <= r_hdr_rdy && old_fmt;
            r_out_total <= r_hdr_rdy ? r_count : 16'h0000;
            r_out_ihit  <= r_idx_found;
            r_out_ioff  <= r_idx_found ? 32'(r_idx_off) : 32'h0;
            r_out_mhit  <= r_mag_found;
            r_out_moff  <= r_mag_found ? 32'(r_mag_off) : 32'h0;
            r_out_bytes <= r_pos;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.file_ok       = r_out_ok;
    assign o_res.old_format    = r_out_old;
    assign o_res.section_total = r_out_total;
    assign o_res.index_hit     = r_out_ihit;
    assign o_res.index_offset  = r_out_ioff;
    assign o_res.magic_hit     = r_out_mhit;
    assign o_res.magic_offset  = r_out_moff;
    assign o_res.total_bytes   = r_out_bytes;

endmodule

FILE: hw/rtl/csw_checker.sv
`include "container_section_walker_defines.svh"

module csw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic        i_file_ok,
    input logic        i_index_hit,
    input logic [31:0] i_index_offset,
    input logic        i_magic_hit,
    input logic [31:0] i_magic_offset,
    input logic [31:0] i_total_bytes
);

    logic        res_stall;
    logic [63:0] res_held;
    logic        miss_zero;
    logic        index_fits;
    logic        magic_fits;

    assign res_stall  = i_res_valid && !i_res_ready;
    assign res_held   = {i_total_bytes, i_index_offset};
    assign miss_zero  = (i_index_hit || (i_index_offset == 32'd0))
                        && (i_magic_hit || (i_magic_offset == 32'd0));
    assign index_fits = (33'(i_index_offset) + 33'd8) <= 33'(i_total_bytes);
    assign magic_fits = (33'(i_magic_offset) + 33'd8) <= 33'(i_total_bytes);

    `CSW_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, res_stall, i_res_valid && $stable(res_held))
    `CSW_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, i_res_valid, miss_zero)
    `CSW_ASSERT_NOW(a_index_fits, i_clk, i_rst_n, i_res_valid && i_index_hit, index_fits)
    `CSW_ASSERT_NOW(a_magic_fits, i_clk, i_rst_n, i_res_valid && i_magic_hit, magic_fits)
    `CSW_ASSERT_NOW(a_ok_long, i_clk, i_rst_n, i_res_valid && i_file_ok, i_total_bytes >= 32'd16)

endmodule

bind container_section_walker csw_checker u_csw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_file_ok      (o_res.file_ok),
    .i_index_hit    (o_res.index_hit),
    .i_index_offset (o_res.index_offset),
    .i_magic_hit    (o_res.magic_hit),
    .i_magic_offset (o_res.magic_offset),
    .i_total_bytes  (o_res.total_bytes)
);

FILE: tb/sv/tb_top.sv
module tb_top;
    import csw_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES  = 24;
    localparam int TARGET_BYTES   = 1450;
    localparam int MIN_FILES      = 30;
    localparam int BUILD_SPAN     = 512;
    localparam logic [CFG_IDX_W-1:0] REG_VOID = {CFG_IDX_W{1'b1}};
    localparam bit [63:0] WALK_LIMIT = 64'(OFF_LIMIT);

    typedef enum {DECL_EXACT, DECL_OLD, DECL_ROUND, DECL_JUNK} t_decl;
    typedef enum {LEN_NORMAL, LEN_ZERO, LEN_HUGE} t_len_style;

    typedef struct {
        logic        file_ok;
        logic        old_format;
        logic [15:0] section_total;
        logic        index_hit;
        logic [31:0] index_offset;
        logic        magic_hit;
        logic [31:0] magic_offset;
        logic [31:0] total_bytes;
    } t_file_summary;

    class section_walk_tracker;
        bit [15:0]     want_index;
        bit [31:0]     want_magic;
        bit [31:0]     pos;
        bit [63:0]     window;
        bit [63:0]     head;
        bit [15:0]     marker;
        bit [31:0]     decl_len;
        bit [15:0]     hdr_len;
        bit [15:0]     sec_count;
        bit            hdr_ready;
        bit [63:0]     next_off;
        bit [15:0]     sec_seen;
        bit            idx_found;
        bit [63:0]     idx_off;
        bit            mag_found;
        bit [63:0]     mag_off;
        t_file_summary summaries_due[$];
        int            errors;

        function new();
            want_index = '0;
            want_magic = '0;
            errors     = 0;
            restart();
        endfunction

        function void restart();
            pos       = '0;
            window    = '0;
            head      = '0;
            marker    = '0;
            decl_len  = '0;
            hdr_len   = '0;
            sec_count = '0;
            hdr_ready = 1'b0;
            next_off  = '0;
            sec_seen  = '0;
            idx_found = 1'b0;
            idx_off   = '0;
            mag_found = 1'b0;
            mag_off   = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_TARGET_INDEX) begin
                want_index = val[15:0];
            end else if (idx == REG_TARGET_MAGIC) begin
                want_magic = val[31:0];
            end
        endfunction

        // last 8 bytes live in the window, bytes 0..7 are kept aside
        function bit [7:0] byte_at(bit [63:0] q);
            bit [63:0] base;
            base = 64'(pos) - 64'd8;
            if (pos >= 8 && q >= base && q < 64'(pos)) return 8'(window >> (8 * (q - base)));
            if (q < 8) return 8'(head >> (8 * q));
            return 8'h00;
        endfunction

        function bit [31:0] word_at(bit [63:0] q);
            return {byte_at(q + 3), byte_at(q + 2), byte_at(q + 1), byte_at(q)};
        endfunction

        function void walk();
            bit [63:0] o;
            bit [63:0] len;
            bit [31:0] tag;
            while (hdr_ready && sec_seen < sec_count && next_off < WALK_LIMIT &&
                   next_off + SEC_HDR_BYTES <= 64'(pos)) begin
                o   = next_off;
                tag = word_at(o);
                len = 64'(word_at(o + 4));
                if (sec_seen == want_index && !idx_found) begin
                    idx_found = 1'b1;
                    idx_off   = o;
                end
                if (!mag_found && tag == want_magic) begin
                    mag_found = 1'b1;
                    mag_off   = o;
                end
                sec_seen++;
                o += len + ((marker == 16'h0000) ? 64'd8 : 64'd0);
                next_off = (o > WALK_LIMIT) ? WALK_LIMIT : o;
            end
        endfunction

        function void take_byte(logic [7:0] d, logic last);
            t_file_summary s;
            bit [63:0]     size;
            bit [63:0]     dl;
            bit            old_fmt;
            bit            ok;
            if (pos != POS_MAX) begin
                window = {d, window[63:8]};
                pos++;
                if (pos == POS_HEAD_DONE) head = window;
                if (pos == POS_HDR_DONE) begin
                    marker    = head[47:32];
                    decl_len  = window[31:0];
                    hdr_len   = window[47:32];
                    sec_count = window[63:48];
                    next_off  = 64'(window[47:32]);
                    hdr_ready = 1'b1;
                end
                walk();
            end
            if (!last) return;

            size    = 64'(pos);
            dl      = 64'(decl_len);
            old_fmt = hdr_ready && marker == 16'h0000;
            ok      = hdr_ready;
            if (ok && marker != MARK_BOM_A && marker != MARK_BOM_B && marker != 16'h0000)
                ok = 1'b0;
            if (ok && !(dl == size || (old_fmt && dl + 8 == size) ||
                        ((dl + 3) & ~64'd3) == size))
                ok = 1'b0;
            if (ok && hdr_len < HLEN_MIN) ok = 1'b0;
            if (ok && sec_seen != sec_count) ok = 1'b0;

            s.file_ok       = ok;
            s.old_format    = old_fmt;
            s.section_total = hdr_ready ? sec_count : 16'h0000;
            s.index_hit     = idx_found;
            s.index_offset  = idx_found ? idx_off[31:0] : 32'h0;
            s.magic_hit     = mag_found;
            s.magic_offset  = mag_found ? mag_off[31:0] : 32'h0;
            s.total_bytes   = pos;
            summaries_due.push_back(s);
            restart();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_summary(t_file_summary got);
            t_file_summary want;
            if (summaries_due.size() == 0) begin
                report("result with no file pending");
                return;
            end
            want = summaries_due.pop_front();
            if (got.file_ok !== want.file_ok)
                report($sformatf("file_ok %b, want %b", got.file_ok, want.file_ok));
            if (got.old_format !== want.old_format)
                report($sformatf("old_format %b, want %b", got.old_format, want.old_format));
            if (got.section_total !== want.section_total)
                report($sformatf("section_total %h, want %h",
                                 got.section_total, want.section_total));
            if (got.index_hit !== want.index_hit)
                report($sformatf("index_hit %b, want %b", got.index_hit, want.index_hit));
            if (got.index_offset !== want.index_offset)
                report($sformatf("index_offset %h, want %h",
                                 got.index_offset, want.index_offset));
            if (got.magic_hit !== want.magic_hit)
                report($sformatf("magic_hit %b, want %b", got.magic_hit, want.magic_hit));
            if (got.magic_offset !== want.magic_offset)
                report($sformatf("magic_offset %h, want %h",
                                 got.magic_offset, want.magic_offset));
            if (got.total_bytes !== want.total_bytes)
                report($sformatf("total_bytes %h, want %h", got.total_bytes, want.total_bytes));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    csw_in_if  in_ch();
    csw_res_if res_ch();
    csw_cfg_if cfg_ch();

    container_section_walker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    section_walk_tracker walk_tracker = new();
    logic [7:0]  file_bytes[$];
    logic [31:0] tags[4];
    int in_gap_max   = 9;
    int res_gap_max  = 9;
    int res_stall    = 0;
    int quiet_cycles = 0;
    int bytes_sent   = 0;
    int files_sent   = 0;

    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data_byte = '0;
        in_ch.last_byte = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
    end

    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (res_stall > 0) begin
                res_ch.ready = 1'b0;
                res_stall--;
            end else begin
                res_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_file_summary got;
        bit            moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (in_ch.valid && in_ch.ready) begin
                walk_tracker.take_byte(in_ch.data_byte, in_ch.last_byte);
                moved = 1'b1;
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                walk_tracker.set_reg(cfg_ch.index, cfg_ch.data);
                moved = 1'b1;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.file_ok       = res_ch.file_ok;
                got.old_format    = res_ch.old_format;
                got.section_total = res_ch.section_total;
                got.index_hit     = res_ch.index_hit;
                got.index_offset  = res_ch.index_offset;
                got.magic_hit     = res_ch.magic_hit;
                got.magic_offset  = res_ch.magic_offset;
                got.total_bytes   = res_ch.total_bytes;
                walk_tracker.check_summary(got);
                res_stall = $urandom_range(0, res_gap_max);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic void put8(int p, logic [7:0] v);
        while (file_bytes.size() <= p) file_bytes.push_back(8'($urandom()));
        file_bytes[p] = v;
    endfunction

    function automatic void put16(int p, logic [15:0] v);
        put8(p, v[7:0]);
        put8(p + 1, v[15:8]);
    endfunction

    function automatic void put32(int p, logic [31:0] v);
        put16(p, v[15:0]);
        put16(p + 2, v[31:16]);
    endfunction

    function automatic logic [31:0] pick_tag();
        int r;
        r = $urandom_range(0, 5);
        if (r < 4) return tags[r];
        return $urandom();
    endfunction

    function automatic logic [31:0] section_len(bit old_fmt, t_len_style style);
        if (style == LEN_ZERO) return 32'h0;
        if (style == LEN_HUGE) return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
        if (old_fmt) return $urandom_range(0, 16);
        // overlapping headers now and then
        if ($urandom_range(0, 11) == 0) return $urandom_range(0, 7);
        return $urandom_range(8, 24);
    endfunction

    task automatic compose(logic [15:0] mark, logic [15:0] hlen, int nsec,
                           logic [15:0] cnt, t_decl dmode, t_len_style style);
        longint unsigned o;
        longint unsigned adv;
        logic [31:0]     len;
        logic [31:0]     decl;
        int              size;
        file_bytes.delete();
        repeat (16) file_bytes.push_back(8'($urandom()));
        o = 64'(hlen);
        for (int i = 0; i < nsec; i++) begin
            if (o > BUILD_SPAN) break;
            len = section_len(mark == 16'h0000, style);
            put32(int'(o), pick_tag());
            put32(int'(o) + 4, len);
            adv = longint'(len) + ((mark == 16'h0000) ? 8 : 0);
            o += adv;
            if (adv == 0) break;
        end
        if (o <= BUILD_SPAN)
            while (file_bytes.size() < o) file_bytes.push_back(8'($urandom()));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom()));
        if (dmode == DECL_ROUND)
            while (file_bytes.size() % 4 != 0) file_bytes.push_back(8'($urandom()));
        size = file_bytes.size();
        case (dmode)
            DECL_EXACT: decl = size;
            DECL_OLD:   decl = size - 8;
            DECL_ROUND: decl = size - $urandom_range(0, 3);
            default:    decl = $urandom();
        endcase
        put16(4, mark);
        put32(8, decl);
        put16(12, hlen);
        put16(14, cnt);
    endtask

    task automatic send_byte(logic [7:0] d, logic last);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid     = 1'b1;
        in_ch.data_byte = d;
        in_ch.last_byte = last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_file();
        foreach (file_bytes[k]) send_byte(file_bytes[k], k == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
        if (idx == REG_TARGET_MAGIC) tags[0] = val;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        while (walk_tracker.summaries_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic retarget();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) write_reg(REG_TARGET_INDEX, $urandom_range(0, 5));
        else if (r == 6) write_reg(REG_TARGET_INDEX, 32'h0);
        else if (r == 7) write_reg(REG_TARGET_INDEX, 32'h0000_FFFF);
        else if (r == 8) write_reg(REG_TARGET_INDEX, $urandom());
        r = $urandom_range(0, 9);
        if (r < 4) write_reg(REG_TARGET_MAGIC, tags[$urandom_range(1, 3)]);
        else if (r == 4) write_reg(REG_TARGET_MAGIC, 32'h0);
        else if (r == 5) write_reg(REG_TARGET_MAGIC, 32'hFFFF_FFFF);
        else if (r == 6) write_reg(REG_TARGET_MAGIC, $urandom());
        in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : 9;
        res_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
    endtask

    task automatic random_file();
        int          r;
        int          nsec;
        logic [15:0] mark;
        logic [15:0] hlen;
        logic [15:0] cnt;
        t_decl       dmode;
        t_len_style  style;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            file_bytes.delete();
            repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom()));
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: mark = 16'h0000;
                4, 5, 6:    mark = MARK_BOM_A;
                7, 8:       mark = MARK_BOM_B;
                default:    mark = 16'($urandom());
            endcase
            case ($urandom_range(0, 9))
                0, 1:    hlen = 16'(16 + $urandom_range(1, 12));
                2:       hlen = 16'($urandom_range(0, 15));
                default: hlen = 16'd16;
            endcase
            nsec = $urandom_range(0, 5);
            case ($urandom_range(0, 19))
                16, 17:  cnt = 16'(nsec + 1);
                18:      cnt = 16'($urandom_range(0, 65535));
                19:      cnt = (nsec > 0) ? 16'(nsec - 1) : 16'h0000;
                default: cnt = 16'(nsec);
            endcase
            case ($urandom_range(0, 19))
                12, 13, 14, 15: dmode = DECL_ROUND;
                16, 17, 18:     dmode = (mark == 16'h0000) ? DECL_OLD : DECL_EXACT;
                19:             dmode = DECL_JUNK;
                default:        dmode = DECL_EXACT;
            endcase
            case ($urandom_range(0, 29))
                0:       style = LEN_ZERO;
                1:       style = LEN_HUGE;
                default: style = LEN_NORMAL;
            endcase
            compose(mark, hlen, nsec, cnt, dmode, style);
            // cut short now and then
            if (r < 3) begin
                r = $urandom_range(1, file_bytes.size());
                while (file_bytes.size() > r) void'(file_bytes.pop_back());
            end
        end
        send_file();
    endtask

    initial begin : stimulus
        tags[0] = 32'h0;
        tags[1] = 32'h0;
        tags[2] = 32'hFFFF_FFFF;
        tags[3] = 32'h5EC7_0A11;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        write_reg(REG_TARGET_INDEX, 32'h1);
        write_reg(REG_TARGET_MAGIC, 32'h5EC7_0A11);
        write_reg(REG_VOID, 32'hFFFF_FFFF);

        file_bytes = '{8'hFF};
        send_file();
        file_bytes.delete();
        for (int i = 0; i < 15; i++) file_bytes.push_back(i[0] ? 8'hFF : 8'h00);
        send_file();
        compose(MARK_BOM_A, 16, 0, 0, DECL_EXACT, LEN_NORMAL);
        send_file();
        compose(MARK_BOM_B, 16, 3, 3, DECL_EXACT, LEN_NORMAL);
        send_file();
        compose(16'h0000, 16, 2, 2, DECL_OLD, LEN_NORMAL);
        send_file();
        compose(16'h1234, 16, 1, 1, DECL_EXACT, LEN_NORMAL);
        send_file();
        // walk starts inside the file header
        compose(MARK_BOM_A, 0, 1, 1, DECL_EXACT, LEN_NORMAL);
        send_file();
        compose(MARK_BOM_A, 4, 2, 2, DECL_EXACT, LEN_NORMAL);
        send_file();
        // next offset reaches and passes the 32-bit range
        compose(MARK_BOM_A, 16, 2, 2, DECL_EXACT, LEN_HUGE);
        send_file();
        compose(16'h0000, 16, 2, 1, DECL_EXACT, LEN_HUGE);
        send_file();
        compose(MARK_BOM_B, 16, 3, 4, DECL_EXACT, LEN_NORMAL);
        send_file();
        compose(MARK_BOM_B, 20, 2, 2, DECL_ROUND, LEN_NORMAL);
        send_file();
        drain();

        // every counted section sits on one zero-length header
        write_reg(REG_TARGET_INDEX, 32'h0000_FFFE);
        write_reg(REG_TARGET_MAGIC, 32'hFFFF_FFFF);
        compose(MARK_BOM_A, 16, 1, 16'hFFFF, DECL_EXACT, LEN_ZERO);
        send_file();
        drain();

        write_reg(REG_TARGET_INDEX, 32'h0000_FFFF);
        write_reg(REG_TARGET_MAGIC, 32'h0);
        compose(16'h0000, 16, 3, 3, DECL_EXACT, LEN_NORMAL);
        send_file();
        drain();

        while (bytes_sent < TARGET_BYTES || files_sent < MIN_FILES) begin
            retarget();
            repeat ($urandom_range(3, 8)) random_file();
            drain();
        end

        if (walk_tracker.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
